FILE: rtl/sha1bc_pkg.sv
// ----------------------------------------------------------------------------
// sha1bc_pkg
// Types, constants and round helpers for the SHA-1 block compression core.
// ----------------------------------------------------------------------------
package sha1bc_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned HASH_WORDS  = 5;

	localparam logic [6:0] LAST_ROUND   = 7'd79;
	localparam logic [6:0] SCHED_ROUNDS = 7'd16;
	localparam logic [6:0] PHASE1_START = 7'd20;
	localparam logic [6:0] PHASE2_START = 7'd40;
	localparam logic [6:0] PHASE3_START = 7'd60;
	localparam logic [6:0] LAST_ADD     = 7'd4;
	localparam logic [3:0] LAST_WORD    = 4'd15;

	localparam word_t IV [HASH_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR3
	} phase_t;

	function automatic word_t round_k(input phase_t ph);
		word_t k;
		unique case (ph)
			PH_CH:   k = 32'h5a827999;
			PH_PAR1: k = 32'h6ed9eba1;
			PH_MAJ:  k = 32'h8f1bbcdc;
			PH_PAR3: k = 32'hca62c1d6;
			default: k = 32'h5a827999;
		endcase
		return k;
	endfunction

	function automatic word_t round_f(input phase_t ph, input word_t b, input word_t c,
		input word_t d);
		word_t f;
		unique case (ph)
			PH_CH:   f = (b & c) | (~b & d);
			PH_MAJ:  f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

	function automatic word_t rotl(input word_t v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

endpackage

FILE: rtl/sha1_block_compress.sv
// ----------------------------------------------------------------------------
// sha1_block_compress
// SHA-1 compression of 16-word blocks with one round adder reused 80 times.
// ----------------------------------------------------------------------------
// Steps: 16 input words are taken, then 80 rounds, 5 add-back steps and one
// load of the output register. A new block is taken only once the result
// of the last one is in the output register.
// Input is not ready during rounds, add-back and while a finished block waits
// for the output register. Reset loads the SHA-1 initial chaining values and
// clears the word count.
// ----------------------------------------------------------------------------
module sha1_block_compress (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [31:0]    s_axis_tdata,   // message_word
	input  logic           s_axis_tuser,   // message_start
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [159:0]   m_axis_tdata    // hash_a, hash_b, hash_c, hash_d, hash_e
);
	import sha1bc_pkg::*;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_ROUND,
		ST_ADD,
		ST_FINAL
	} state_t;

	state_t      state_q;
	logic [6:0]  cnt_q;
	logic [3:0]  word_cnt_q;
	word_t       h_q [HASH_WORDS];
	word_t       w_q [BLOCK_WORDS];
	word_t       a_q, b_q, c_q, d_q, e_q;
	logic        out_valid_q;
	logic [159:0] out_data_q;

	logic        in_acc;
	logic        last_word;
	phase_t      phase;
	word_t       wt;
	word_t       t_sum;
	word_t       add_sum;

	assign s_axis_tready = (state_q == ST_COLLECT);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign last_word     = (word_cnt_q == LAST_WORD);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		priority if (cnt_q < PHASE1_START) begin
			phase = PH_CH;
		end else if (cnt_q < PHASE2_START) begin
			phase = PH_PAR1;
		end else if (cnt_q < PHASE3_START) begin
			phase = PH_MAJ;
		end else begin
			phase = PH_PAR3;
		end
	end

	always_comb begin
		if (cnt_q < SCHED_ROUNDS) begin
			wt = w_q[0];
		end else begin
			wt = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		end
	end

	assign t_sum   = rotl(a_q, 5) + round_f(phase, b_q, c_q, d_q) + e_q + wt + round_k(phase);
	assign add_sum = h_q[0] + a_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= s_axis_tdata;
			if (last_word) begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= wt;
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end else if (state_q == ST_ADD) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= e_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			cnt_q       <= '0;
			word_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			for (int i = 0; i < HASH_WORDS; i++) begin
				h_q[i] <= IV[i];
			end
		end else begin
			if (out_valid_q && m_axis_tready && state_q != ST_FINAL) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (in_acc) begin
						word_cnt_q <= word_cnt_q + 4'd1;
						if (word_cnt_q == '0 && s_axis_tuser) begin
							for (int i = 0; i < HASH_WORDS; i++) begin
								h_q[i] <= IV[i];
							end
						end
						if (last_word) begin
							cnt_q   <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					if (cnt_q == LAST_ROUND) begin
						cnt_q   <= '0;
						state_q <= ST_ADD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < HASH_WORDS - 1; i++) begin
						h_q[i] <= h_q[i + 1];
					end
					h_q[HASH_WORDS - 1] <= add_sum;
					if (cnt_q == LAST_ADD) begin
						cnt_q   <= '0;
						state_q <= ST_FINAL;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_FINAL: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {h_q[4], h_q[3], h_q[2], h_q[1], h_q[0]};
						state_q     <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_ROUND)
		else $error("round counter out of range");

	a_last_word_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_word |=> state_q == ST_ROUND && cnt_q == '0)
		else $error("sixteenth item did not start rounds");

	a_rounds_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && cnt_q == LAST_ROUND |=> state_q == ST_ADD)
		else $error("rounds did not end in add-back");

	a_result_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINAL)
		else $error("result raised outside final step");

	a_words_idle_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_COLLECT |-> word_cnt_q == '0)
		else $error("word count not wrapped during compression");

endmodule

FILE: sim/sha1_block_compress_test.sv
// ----------------------------------------------------------------------------
// sha1_block_compress_test
// Streams 16-word message blocks into the SHA-1 compression core and checks
// every emitted chaining value against a behavioral SHA-1 predictor. Covers
// chaining without a start flag, start flags ignored mid-block, word extremes,
// random traffic under input and output idling, a long output stall and a
// full drain between blocks.
// ----------------------------------------------------------------------------
module sha1_block_compress_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1bc_pkg::*;

	typedef logic [159:0] digest_t;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int TAIL_CYCLES = 120;

	localparam digest_t IV_DIGEST = {IV[4], IV[3], IV[2], IV[1], IV[0]};

	logic           clk;
	logic           arst_n;
	logic           s_axis_tvalid;
	logic           s_axis_tready;
	logic [31:0]    s_axis_tdata;   // message_word
	logic           s_axis_tuser;   // message_start
	logic           m_axis_tvalid;
	logic           m_axis_tready;
	logic [159:0]   m_axis_tdata;   // hash_a, hash_b, hash_c, hash_d, hash_e

	int             tx_idle_pct;
	int             rx_idle_pct;
	logic           rx_hold_req;
	int             mismatch_cnt;

	digest_t        chain_state;
	word_t          block_buf [BLOCK_WORDS];
	logic [3:0]     word_idx;
	digest_t        digest_q [$];

	string          hash_names [HASH_WORDS] = '{"hash_a", "hash_b", "hash_c", "hash_d",
		"hash_e"};

	sha1_block_compress uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic digest_t sha1_rounds(input digest_t chain, input word_t blk [BLOCK_WORDS]);
		word_t  w [BLOCK_WORDS];
		word_t  a, b, c, d, e, wt, f, k, sum;
		phase_t ph;
		w = blk;
		a = chain[31:0];
		b = chain[63:32];
		c = chain[95:64];
		d = chain[127:96];
		e = chain[159:128];
		for (int t = 0; t < 80; t++) begin
			ph = phase_t'(t / 20);
			if (t < 16) begin
				wt = w[t];
			end else begin
				wt = w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16];
				wt = {wt[30:0], wt[31]};
				w[t % 16] = wt;
			end
			case (ph)
				PH_CH: begin
					f = (b & c) | (~b & d);
					k = 32'h5a827999;
				end
				PH_PAR1: begin
					f = b ^ c ^ d;
					k = 32'h6ed9eba1;
				end
				PH_MAJ: begin
					f = (b & c) | (b & d) | (c & d);
					k = 32'h8f1bbcdc;
				end
				default: begin
					f = b ^ c ^ d;
					k = 32'hca62c1d6;
				end
			endcase
			sum = {a[26:0], a[31:27]} + f + e + wt + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		return {chain[159:128] + e, chain[127:96] + d, chain[95:64] + c, chain[63:32] + b,
			chain[31:0] + a};
	endfunction

	task automatic absorb_word(input word_t w, input logic st);
		if (word_idx == 4'd0 && st) begin
			chain_state = IV_DIGEST;
		end
		block_buf[word_idx] = w;
		word_idx++;
		if (word_idx == 4'd0) begin
			chain_state = sha1_rounds(chain_state, block_buf);
			digest_q.push_back(chain_state);
		end
	endtask

	task automatic send_word(input word_t w, input logic st);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = w;
		s_axis_tuser  = st;
		do @(posedge clk); while (!s_axis_tready);
		absorb_word(w, st);
		@(negedge clk);
	endtask

	task automatic send_random_block(input logic st);
		word_t w;
		for (int i = 0; i < BLOCK_WORDS; i++) begin
			case ($urandom_range(9))
				0:       w = '0;
				1:       w = '1;
				default: w = $urandom();
			endcase
			send_word(w, (i == 0) ? st : logic'($urandom_range(1)));
		end
	endtask

	task automatic wait_digests_drained();
		while (digest_q.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		// chain from reset values, start flags mid-block must be ignored
		for (int i = 0; i < BLOCK_WORDS; i++) begin
			send_word(i[0] ? '1 : '0, i != 0);
		end
		// single padded block of "abc" restarted from the initial values
		for (int i = 0; i < BLOCK_WORDS; i++) begin
			send_word((i == 0) ? 32'h61626380 : (i == 15) ? 32'h00000018 : 32'h0, 1'b1);
		end
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int blocks);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (blocks) send_random_block($urandom_range(2) == 0);
	endtask

	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 1'b1;
		repeat (4) send_random_block(logic'($urandom_range(1)));
	endtask

	task automatic test_drain_pause();
		s_axis_tvalid = 1'b0;
		wait_digests_drained();
		send_random_block(1'b1);
		send_random_block(1'b0);
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_digest
		digest_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				$error("result with no block pending: %h", m_axis_tdata);
				mismatch_cnt++;
			end else begin
				want = digest_q.pop_front();
				for (int i = 0; i < HASH_WORDS; i++) begin
					if (m_axis_tdata[32*i +: 32] !== want[32*i +: 32]) begin
						$error("%s: expected %08h, got %08h", hash_names[i],
							want[32*i +: 32], m_axis_tdata[32*i +: 32]);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		int idle_cnt;
		idle_cnt = 0;
		while (idle_cnt < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cnt = 0;
			end else begin
				idle_cnt++;
			end
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		rx_hold_req   = 1'b0;
		mismatch_cnt  = 0;
		chain_state   = IV_DIGEST;
		word_idx      = 4'd0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_traffic(31, 87, 38);
		test_random_traffic(87, 31, 38);
		test_random_traffic(0, 0, 38);
		test_output_stall();
		test_drain_pause();

		s_axis_tvalid = 1'b0;
		wait_digests_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
